FILE: hw/rtl/priority_ready_queue_scheduler_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the priority ready queue scheduler
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_UNIT_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PRQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/prq_pkg.sv
// ---------------------------------------------------------------------------
// prq_pkg
// Types, constants and helpers for the priority ready queue scheduler.
// ---------------------------------------------------------------------------
package prq_pkg;

  localparam int MAX_THREADS = 64;
  localparam int ID_SPACE    = 64;
  localparam int ID_W        = 6;
  localparam int PRI_W       = 2;
  localparam int CMD_W       = 3;
  localparam int PREQ_W      = 4;
  localparam int CNT_W       = 7;
  localparam int Q_AW        = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int LEN_W       = $clog2(MAX_THREADS + 1);
  localparam int IN_W        = 16;
  localparam int OUT_W       = 16;

  typedef logic [ID_W-1:0]  tid_t;
  typedef logic [PRI_W-1:0] pri_t;

  localparam pri_t              TOP_PRIORITY = 2'd3;
  localparam logic [CNT_W-1:0]  LIVE_MAX     = 7'd127;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE     = 3'd0,
    CMD_ACTIVATE   = 3'd1,
    CMD_YIELD      = 3'd2,
    CMD_DEACTIVATE = 3'd3,
    CMD_EXIT       = 3'd4,
    CMD_RUN        = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRI_RD,
    ST_PRI_WAIT,
    ST_SCAN_Q,
    ST_SCAN_P,
    ST_SCAN_C,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS,
    ST_DISP_RD,
    ST_DISP_WR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic en;
    tid_t id;
    pri_t pri;
  } pri_wr_t;

  function automatic pri_t clamp_pri(logic [PREQ_W-1:0] req);
    return (req > PREQ_W'(TOP_PRIORITY)) ? TOP_PRIORITY : req[PRI_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/priority_ready_queue_scheduler_unit.sv
// ---------------------------------------------------------------------------
// priority_ready_queue_scheduler_unit
// Cooperative thread scheduler with a priority-ordered ready queue held in
// a circular memory, driven by a small sequencer around one address unit.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata fields, low bit up
//  s_axis   | in  | command[2:0] thread_id[8:3] priority_req[12:9] zero[15:13]
//  m_axis   | out | run_thread[5:0] next_is_main[6] switched[7]
//           |     | ready_count[14:8] status[15]
//
// One command at a time. Deactivate, exit and run go through the dispatch
// states and then the result register; a no-op or a refused insert goes
// straight to it. A create walks the queue from the head, reading each
// entry's priority, until a lower-priority entry or the queue end stops the
// walk, then moves the tail back one entry at a time through the one-port
// queue memory and inserts. Activate first reads the stored priority; yield
// does that and then dispatches the head.
// A new command is taken while the last result waits on m_axis_tready.
// Synchronous reset empties the queue and clears all stored priorities.
// ---------------------------------------------------------------------------
module priority_ready_queue_scheduler_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // command[2:0], thread_id[8:3], priority_req[12:9], zero[15:13]
  input  logic [prq_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // run_thread[5:0], next_is_main[6], switched[7], ready_count[14:8], status[15]
  output logic [prq_pkg::OUT_W-1:0] m_axis_tdata
);
  import prq_pkg::*;

  localparam int SUM_W = Q_AW + 1;

  state_t             state, state_next;
  tid_t               ins_id, ins_id_next;
  pri_t               p_new, p_new_next;
  logic               do_disp, do_disp_next;
  logic               sw_flag, sw_flag_next;
  logic               st_flag, st_flag_next;
  logic [LEN_W-1:0]   pos, pos_next;
  logic [LEN_W-1:0]   k, k_next;
  logic [Q_AW-1:0]    head, head_next;
  logic [LEN_W-1:0]   len, len_next;
  tid_t               run_id, run_id_next;
  logic               run_main, run_main_next;
  logic [CNT_W-1:0]   live, live_next;
  logic               o_valid, o_valid_next;
  logic [OUT_W-1:0]   o_data, o_data_next;

  logic [CMD_W-1:0]   in_cmd;
  tid_t               in_id;
  logic [PREQ_W-1:0]  in_preq;
  logic               id_ok;
  logic               q_full;

  // queue memory and its shared address unit
  tid_t               q_mem [MAX_THREADS];
  tid_t               q_rd;
  logic [LEN_W-1:0]   q_off;
  logic [SUM_W-1:0]   addr_sum;
  logic [Q_AW-1:0]    q_addr;
  logic               q_we;
  tid_t               q_wdata;

  pri_wr_t            pri_wr;
  tid_t               pri_rd_id;
  pri_t               pri_rd;

  assign in_cmd  = s_axis_tdata[CMD_W-1:0];
  assign in_id   = s_axis_tdata[CMD_W +: ID_W];
  assign in_preq = s_axis_tdata[CMD_W+ID_W +: PREQ_W];
  assign id_ok   = (32'(in_id) < MAX_THREADS);
  assign q_full  = (len == LEN_W'(MAX_THREADS));

  assign addr_sum = SUM_W'(head) + SUM_W'(q_off);
  assign q_addr   = (addr_sum >= SUM_W'(MAX_THREADS))
                  ? Q_AW'(addr_sum - SUM_W'(MAX_THREADS))
                  : addr_sum[Q_AW-1:0];

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_addr] <= q_wdata;
    end
    q_rd <= q_mem[q_addr];
  end

  prq_prio_store u_prio_store (
    .clk    (clk),
    .rst    (rst),
    .wr     (pri_wr),
    .rd_id  (pri_rd_id),
    .rd_pri (pri_rd)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      len      <= '0;
      run_id   <= '0;
      run_main <= 1'b1;
      live     <= '0;
      o_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      len      <= len_next;
      run_id   <= run_id_next;
      run_main <= run_main_next;
      live     <= live_next;
      o_valid  <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ins_id  <= ins_id_next;
    p_new   <= p_new_next;
    do_disp <= do_disp_next;
    sw_flag <= sw_flag_next;
    st_flag <= st_flag_next;
    pos     <= pos_next;
    k       <= k_next;
    o_data  <= o_data_next;
  end

  always_comb begin
    state_next    = state;
    ins_id_next   = ins_id;
    p_new_next    = p_new;
    do_disp_next  = do_disp;
    sw_flag_next  = sw_flag;
    st_flag_next  = st_flag;
    pos_next      = pos;
    k_next        = k;
    head_next     = head;
    len_next      = len;
    run_id_next   = run_id;
    run_main_next = run_main;
    live_next     = live;
    o_valid_next  = o_valid && !m_axis_tready;
    o_data_next   = o_data;
    q_off         = '0;
    q_we          = 1'b0;
    q_wdata       = ins_id;
    pri_wr        = '0;
    pri_rd_id     = ins_id;

    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          sw_flag_next = 1'b0;
          st_flag_next = 1'b0;
          do_disp_next = 1'b0;
          pos_next     = '0;
          ins_id_next  = in_id;
          state_next   = ST_FIN;
          case (in_cmd)
            CMD_CREATE: begin
              if (id_ok && q_full) begin
                st_flag_next = 1'b1;
              end else if (id_ok) begin
                pri_wr     = '{en: 1'b1, id: in_id, pri: clamp_pri(in_preq)};
                p_new_next = clamp_pri(in_preq);
                if (live != LIVE_MAX) begin
                  live_next = live + 7'd1;
                end
                state_next = ST_SCAN_Q;
              end
            end
            CMD_ACTIVATE: begin
              if (id_ok && q_full) begin
                st_flag_next = 1'b1;
              end else if (id_ok) begin
                state_next = ST_PRI_RD;
              end
            end
            CMD_YIELD: begin
              if (len != '0 && !run_main) begin
                if (q_full) begin
                  st_flag_next = 1'b1;
                end else begin
                  ins_id_next  = run_id;
                  do_disp_next = 1'b1;
                  state_next   = ST_PRI_RD;
                end
              end
            end
            CMD_DEACTIVATE: begin
              state_next = ST_DISP_RD;
            end
            CMD_EXIT: begin
              if (live != '0) begin
                live_next = live - 7'd1;
              end
              state_next = ST_DISP_RD;
            end
            CMD_RUN: begin
              if (len != '0) begin
                state_next = ST_DISP_RD;
              end
            end
            default: begin
              state_next = ST_FIN;
            end
          endcase
        end
      end
      ST_PRI_RD: begin
        pri_rd_id  = ins_id;
        state_next = ST_PRI_WAIT;
      end
      ST_PRI_WAIT: begin
        p_new_next = pri_rd;
        state_next = ST_SCAN_Q;
      end
      // walk from the head until an entry of lower priority turns up or the queue ends
      ST_SCAN_Q: begin
        if (pos == len) begin
          k_next     = len;
          state_next = ST_SH_RD;
        end else begin
          q_off      = pos;
          state_next = ST_SCAN_P;
        end
      end
      ST_SCAN_P: begin
        pri_rd_id  = q_rd;
        state_next = ST_SCAN_C;
      end
      ST_SCAN_C: begin
        if (pri_rd >= p_new) begin
          pos_next   = pos + LEN_W'(1);
          state_next = ST_SCAN_Q;
        end else begin
          k_next     = len;
          state_next = ST_SH_RD;
        end
      end
      // open a slot at the insert position, moving the tail back by one
      ST_SH_RD: begin
        if (k > pos) begin
          q_off      = k - LEN_W'(1);
          state_next = ST_SH_WR;
        end else begin
          state_next = ST_INS;
        end
      end
      ST_SH_WR: begin
        q_off      = k;
        q_we       = 1'b1;
        q_wdata    = q_rd;
        k_next     = k - LEN_W'(1);
        state_next = ST_SH_RD;
      end
      ST_INS: begin
        q_off      = pos;
        q_we       = 1'b1;
        q_wdata    = ins_id;
        len_next   = len + LEN_W'(1);
        state_next = do_disp ? ST_DISP_RD : ST_FIN;
      end
      ST_DISP_RD: begin
        sw_flag_next = 1'b1;
        if (len == '0) begin
          run_id_next   = '0;
          run_main_next = 1'b1;
          state_next    = ST_FIN;
        end else begin
          q_off      = '0;
          state_next = ST_DISP_WR;
        end
      end
      ST_DISP_WR: begin
        run_id_next   = q_rd;
        run_main_next = 1'b0;
        q_off         = LEN_W'(1);
        head_next     = q_addr;
        len_next      = len - LEN_W'(1);
        state_next    = ST_FIN;
      end
      // hold until the result register is free
      ST_FIN: begin
        if (!o_valid || m_axis_tready) begin
          o_valid_next = 1'b1;
          o_data_next  = {st_flag, CNT_W'(len), sw_flag, run_main,
                          (run_main ? tid_t'(0) : run_id)};
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/prq_prio_store.sv
// ---------------------------------------------------------------------------
// prq_prio_store
// Per-thread priority memory with one registered read port. Entries never
// written since reset read as priority zero.
// ---------------------------------------------------------------------------
module prq_prio_store (
  input  logic             clk,
  input  logic             rst,
  input  prq_pkg::pri_wr_t wr,
  input  prq_pkg::tid_t    rd_id,
  output prq_pkg::pri_t    rd_pri
);
  import prq_pkg::*;

  pri_t                mem [ID_SPACE];
  logic [ID_SPACE-1:0] valid;
  pri_t                rd_raw;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.id] <= wr.pri;
    end
    rd_raw <= mem[rd_id];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.id] <= 1'b1;
      end
      rd_valid <= valid[rd_id];
    end
  end

  assign rd_pri = rd_valid ? rd_raw : '0;

endmodule

FILE: hw/rtl/prq_checker.sv
// ---------------------------------------------------------------------------
// prq_checker
// Port-level checks for the priority ready queue scheduler, bound to the
// top level.
// ---------------------------------------------------------------------------
`include "priority_ready_queue_scheduler_unit_defines.svh"

module prq_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [prq_pkg::IN_W-1:0]  s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [prq_pkg::OUT_W-1:0] m_axis_tdata
);
  import prq_pkg::*;

  // a stalled result holds
  `PRQ_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // one command in flight: input closes after each transfer
  `PRQ_ASSERT_NXT(a_busy_after_take, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input still open after a transfer")

  `PRQ_ASSERT_IMP(a_main_zero_id, clk, rst, m_axis_tvalid && m_axis_tdata[6], m_axis_tdata[5:0] == 6'd0, "main context with nonzero thread id")

  `PRQ_ASSERT_IMP(a_full_no_switch, clk, rst, m_axis_tvalid && m_axis_tdata[15], !m_axis_tdata[7], "refused insert reported a dispatch")

  `PRQ_ASSERT_IMP(a_count_bound, clk, rst, m_axis_tvalid, 32'(m_axis_tdata[14:8]) <= MAX_THREADS, "ready count above queue depth")

endmodule

bind priority_ready_queue_scheduler_unit prq_checker u_prq_checker (.*);

FILE: sim/priority_ready_queue_scheduler_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// priority_ready_queue_scheduler_unit_tb
// Sends scheduler commands over the input stream with random gaps and
// back-pressure. A behavioral copy of the ready queue predicts each result,
// and every field of each returned result is compared against it.
// ---------------------------------------------------------------------------

// Field order matches m_axis_tdata: status on top, run_thread at the bottom.
typedef struct packed {
  logic                      status;
  logic [prq_pkg::CNT_W-1:0] ready_count;
  logic                      switched;
  logic                      next_is_main;
  prq_pkg::tid_t             run_thread;
} sched_result_t;

class sched_scoreboard;
  prq_pkg::tid_t ready_q[$];
  prq_pkg::pri_t thread_pri[prq_pkg::ID_SPACE];
  prq_pkg::tid_t run_id;
  bit            run_main;
  int unsigned   live_count;
  sched_result_t pending[$];
  int unsigned   mismatches;
  int unsigned   checked;

  function new();
    foreach (thread_pri[i]) thread_pri[i] = '0;
    run_id     = '0;
    run_main   = 1'b1;
    live_count = 0;
    mismatches = 0;
    checked    = 0;
  endfunction

  function int queue_len();
    return ready_q.size();
  endfunction

  function bit main_running();
    return run_main;
  endfunction

  function int pending_count();
    return pending.size();
  endfunction

  // Insert behind the leading run of entries of equal or higher stored priority.
  function void enqueue(prq_pkg::tid_t id);
    int pos;
    pos = 0;
    while (pos < ready_q.size() && thread_pri[ready_q[pos]] >= thread_pri[id])
      pos++;
    ready_q.insert(pos, id);
  endfunction

  function void dispatch_head();
    if (ready_q.size() > 0) begin
      run_id   = ready_q.pop_front();
      run_main = 1'b0;
    end else begin
      run_id   = '0;
      run_main = 1'b1;
    end
  endfunction

  function void note_command(logic [prq_pkg::CMD_W-1:0] cmd, prq_pkg::tid_t id,
                             logic [prq_pkg::PREQ_W-1:0] preq);
    sched_result_t r;
    bit            full;
    bit            id_ok;
    full  = ready_q.size() >= prq_pkg::MAX_THREADS;
    id_ok = int'(id) < prq_pkg::MAX_THREADS;
    r     = '0;
    case (cmd)
      prq_pkg::CMD_CREATE: begin
        if (id_ok) begin
          if (full) begin
            r.status = 1'b1;
          end else begin
            thread_pri[id] = (preq > {2'b00, prq_pkg::TOP_PRIORITY}) ?
                             prq_pkg::TOP_PRIORITY : preq[prq_pkg::PRI_W-1:0];
            if (live_count < prq_pkg::LIVE_MAX) live_count++;
            enqueue(id);
          end
        end
      end
      prq_pkg::CMD_ACTIVATE: begin
        if (id_ok) begin
          if (full) r.status = 1'b1;
          else enqueue(id);
        end
      end
      prq_pkg::CMD_YIELD: begin
        // main is never queued; an empty queue leaves the runner in place
        if (ready_q.size() > 0 && !run_main) begin
          if (full) begin
            r.status = 1'b1;
          end else begin
            enqueue(run_id);
            dispatch_head();
            r.switched = 1'b1;
          end
        end
      end
      prq_pkg::CMD_DEACTIVATE: begin
        dispatch_head();
        r.switched = 1'b1;
      end
      prq_pkg::CMD_EXIT: begin
        if (live_count > 0) live_count--;
        dispatch_head();
        r.switched = 1'b1;
      end
      prq_pkg::CMD_RUN: begin
        if (ready_q.size() > 0) begin
          dispatch_head();
          r.switched = 1'b1;
        end
      end
      default: ;
    endcase
    r.run_thread   = run_main ? '0 : run_id;
    r.next_is_main = run_main;
    r.ready_count  = prq_pkg::CNT_W'(ready_q.size());
    pending.push_back(r);
  endfunction

  function void check_result(sched_result_t got);
    sched_result_t want;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d arrived with nothing pending: %h", checked, got);
      return;
    end
    want = pending.pop_front();
    if (got.run_thread !== want.run_thread || got.next_is_main !== want.next_is_main ||
        got.switched !== want.switched || got.ready_count !== want.ready_count ||
        got.status !== want.status) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d mismatch: expected thread %0d main %0b switched %0b",
                 checked, want.run_thread, want.next_is_main, want.switched);
        $display("  count %0d status %0b; got thread %0d main %0b switched %0b",
                 want.ready_count, want.status, got.run_thread, got.next_is_main,
                 got.switched);
        $display("  count %0d status %0b", got.ready_count, got.status);
      end
    end
  endfunction
endclass

module priority_ready_queue_scheduler_unit_tb;
  import prq_pkg::*;

  localparam int ITEM_TARGET  = 1350;
  localparam int STEADY_FIRST = 500;
  localparam int STEADY_LAST  = 750;
  localparam int HOLD_AT      = 900;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 400;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  logic             clk = 1'b0;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  sched_scoreboard sb = new();
  int  sent_count   = 0;
  int  result_count = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  bit  steady       = 1'b0;

  priority_ready_queue_scheduler_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

  // Mostly a small pool of ids so that duplicates and re-creates are common.
  function automatic tid_t rand_id();
    return ($urandom_range(3) == 0) ? tid_t'($urandom_range(63)) : tid_t'($urandom_range(7));
  endfunction

  function automatic logic [PREQ_W-1:0] rand_preq();
    return PREQ_W'($urandom_range(15));
  endfunction

  // Lean toward removals once the queue gets long so the length wanders.
  function automatic logic [CMD_W-1:0] pick_mixed(int qlen);
    int ins_pct;
    int r;
    ins_pct = (qlen > 24) ? 25 : 45;
    r = $urandom_range(99);
    if (r < ins_pct) return r[0] ? CMD_CREATE : CMD_ACTIVATE;
    r = $urandom_range(99);
    if (r < 30) return CMD_YIELD;
    if (r < 50) return CMD_DEACTIVATE;
    if (r < 68) return CMD_EXIT;
    if (r < 92) return CMD_RUN;
    return r[0] ? CMD_SPARE6 : CMD_SPARE7;
  endfunction

  // Call at a falling edge; returns at the falling edge after the transfer.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input tid_t id,
                          input logic [PREQ_W-1:0] preq);
    while (!steady && $urandom_range(99) < 31) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {3'b000, preq, id, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_command(cmd, id, preq);
    sent_count++;
    steady = (sent_count >= STEADY_FIRST && sent_count < STEADY_LAST);
    @(negedge clk);
  endtask

  // Fill the queue to full with a thread running, then poke it 3 to 8 more times.
  task automatic fill_queue();
    int r;
    if (sb.main_running()) begin
      send_cmd(CMD_CREATE, rand_id(), rand_preq());
      send_cmd(CMD_RUN, rand_id(), rand_preq());
    end
    while (sb.queue_len() < MAX_THREADS)
      send_cmd($urandom_range(1) ? CMD_CREATE : CMD_ACTIVATE, rand_id(), rand_preq());
    repeat ($urandom_range(3, 8)) begin
      r = $urandom_range(2);
      send_cmd((r == 0) ? CMD_CREATE : (r == 1) ? CMD_ACTIVATE : CMD_YIELD,
               rand_id(), rand_preq());
    end
  endtask

  task automatic drain_queue();
    int r;
    while (sb.queue_len() > 0)
      send_cmd($urandom_range(1) ? CMD_EXIT : CMD_DEACTIVATE, rand_id(), rand_preq());
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(3);
      send_cmd((r == 0) ? CMD_DEACTIVATE : (r == 1) ? CMD_EXIT :
               (r == 2) ? CMD_YIELD : CMD_RUN, rand_id(), rand_preq());
    end
  endtask

  task automatic mixed_burst(input int n);
    repeat (n) send_cmd(pick_mixed(sb.queue_len()), rand_id(), rand_preq());
  endtask

  // Result side: random stalls, one long hold-off, and a stall-free stretch.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (!hold_done && result_count >= HOLD_AT) begin
        hold_done     = 1'b1;
        hold_left     = HOLD_CYCLES;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = steady || ($urandom_range(99) >= 31);
      end
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        sb.check_result(sched_result_t'(m_axis_tdata));
        result_count++;
      end
    end
  end

  initial begin
    int fills_left;
    int fill_mark;
    int pick;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    fills_left    = 3;
    fill_mark     = 300;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty queue, main running
    send_cmd(CMD_YIELD, 6'd5, 4'd0);
    send_cmd(CMD_RUN, 6'd0, 4'd15);
    send_cmd(CMD_DEACTIVATE, 6'd63, 4'd7);
    send_cmd(CMD_EXIT, 6'd0, 4'd0);
    // priority extremes and clamping
    send_cmd(CMD_CREATE, 6'd0, 4'd0);
    send_cmd(CMD_CREATE, 6'd63, 4'd15);
    send_cmd(CMD_CREATE, 6'd10, 4'd4);
    send_cmd(CMD_CREATE, 6'd20, 4'd2);
    send_cmd(CMD_CREATE, 6'd21, 4'd1);
    send_cmd(CMD_ACTIVATE, 6'd63, 4'd0);
    send_cmd(CMD_ACTIVATE, 6'd42, 4'd9);
    send_cmd(CMD_RUN, 6'd1, 4'd0);
    send_cmd(CMD_YIELD, 6'd2, 4'd8);
    // run while a thread runs drops it
    send_cmd(CMD_RUN, 6'd3, 4'd3);
    // raise priority of a queued thread, then queue it again
    send_cmd(CMD_CREATE, 6'd20, 4'd3);
    send_cmd(CMD_ACTIVATE, 6'd20, 4'd0);
    send_cmd(CMD_SPARE6, 6'd63, 4'd15);
    send_cmd(CMD_SPARE7, 6'd0, 4'd0);
    send_cmd(CMD_YIELD, 6'd9, 4'd1);
    send_cmd(CMD_DEACTIVATE, 6'd11, 4'd2);
    send_cmd(CMD_EXIT, 6'd12, 4'd5);
    drain_queue();

    while (sent_count < ITEM_TARGET) begin
      pick = $urandom_range(9);
      if (fills_left > 0 && sent_count >= fill_mark) begin
        fills_left--;
        fill_mark += 400;
        fill_queue();
      end else if (pick <= 2) begin
        drain_queue();
      end else begin
        mixed_burst($urandom_range(20, 80));
      end
    end
    s_axis_tvalid = 1'b0;

    while (sb.pending_count() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
